[rtl/core/iba_pkg.sv]
// Shared status codes and controller/datapath handshake types for the block allocator.
package iba_pkg;

  localparam int STATUS_W = 3;
  localparam int OUT_SLOT_W = 6;
  localparam int OUT_BLK_W = 9;
  localparam int WORD_BITS = 32;
  localparam int WORD_LSB = 5;
  localparam int GROUP_BITS = 8;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DISK_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DIR_FULL   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_SLOT_EMPTY = 3'd4;

  localparam logic OP_CREATE = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic clr_step;
    logic accept;
    logic scan_step;
    logic row_rd;
    logic load_word;
    logic take;
    logic row_next;
    logic emit_err;
    logic dir_rd;
    logic dir_ld;
    logic free_rd;
    logic free_wr;
    logic data_rd;
    logic data_ld;
  } iba_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic clr_done;
    logic too_large;
    logic scan_found;
    logic scan_last;
    logic disk_full;
    logic word_has_zero;
    logic last;
    logic out_free;
    logic slot_bad;
  } iba_sts_t;

endpackage

[rtl/core/indexed_block_allocator.sv]
// Top level of the indexed block allocator: sequencer plus datapath.
// Indexed file allocation over a free-block bitmap held as 32-bit rows in a memory, with a
// directory of slots. One request is handled at a time. After reset the bitmap is cleared one
// row a cycle, (NUM_BLOCKS+31)/32 rows (16 at the defaults), with in_stall high. A create is
// accepted, then searches the directory a group at a time (8 groups of slots at the defaults),
// then reads and loads each bitmap row visited, writes back each row found full and moves on,
// and takes the lowest free block of the held row for each allocated block once the output
// register is free. A delete is accepted, looks up the slot, then frees the index block and
// each data block in turn, reading each data block number first; each block is freed by a
// read-modify-write of its bitmap row. Too-large creates and deletes of a bad slot give their
// single result without a directory search; directory-full and disk-full errors wait for the
// directory search. Results leave through an output register, so one pending result never
// blocks the next step unless it is stalled.
module indexed_block_allocator #(
  parameter int NUM_BLOCKS      = 512,
  parameter int NUM_FILES       = 64,
  parameter int MAX_DATA_BLOCKS = 5,
  parameter int BLOCK_UNITS     = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [4:0]  in_size_units,
  input  logic [5:0]  in_slot,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [5:0]  out_file_slot,
  output logic [8:0]  out_block_number,
  output logic        out_is_index,
  output logic        out_last
);
  import iba_pkg::*;

  iba_cmd_t cmd;
  iba_sts_t sts;

  // Sequencer
  iba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath
  iba_dp #(
    .NUM_BLOCKS      (NUM_BLOCKS),
    .NUM_FILES       (NUM_FILES),
    .MAX_DATA_BLOCKS (MAX_DATA_BLOCKS),
    .BLOCK_UNITS     (BLOCK_UNITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_opcode),
    .in_size_units    (in_size_units),
    .in_slot          (in_slot),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_file_slot    (out_file_slot),
    .out_block_number (out_block_number),
    .out_is_index     (out_is_index),
    .out_last         (out_last)
  );

endmodule

[rtl/core/iba_dp.sv]
// Datapath of the block allocator: bitmap, directory memories, counters and result register.
module iba_dp #(
  parameter int NUM_BLOCKS      = 512,
  parameter int NUM_FILES       = 64,
  parameter int MAX_DATA_BLOCKS = 5,
  parameter int BLOCK_UNITS     = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  iba_pkg::iba_cmd_t             cmd,
  output iba_pkg::iba_sts_t             sts,
  input  logic                          in_opcode,
  input  logic [4:0]                    in_size_units,
  input  logic [5:0]                    in_slot,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [iba_pkg::STATUS_W-1:0]  out_status,
  output logic [iba_pkg::OUT_SLOT_W-1:0] out_file_slot,
  output logic [iba_pkg::OUT_BLK_W-1:0] out_block_number,
  output logic                          out_is_index,
  output logic                          out_last
);
  import iba_pkg::*;

  localparam int ROWS   = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int BKW    = RW + WORD_LSB;
  localparam int SW     = $clog2(NUM_FILES);
  localparam int GROUPS = (NUM_FILES + GROUP_BITS - 1) / GROUP_BITS;
  localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int PADW   = GROUPS * GROUP_BITS;
  localparam int NW     = (MAX_DATA_BLOCKS > 1) ? $clog2(MAX_DATA_BLOCKS + 1) : 1;
  localparam int KW     = $clog2(MAX_DATA_BLOCKS + 2);
  localparam int DD     = NUM_FILES * MAX_DATA_BLOCKS;
  localparam int AW     = $clog2(DD);
  localparam int NFW    = $clog2(NUM_BLOCKS + 1);
  localparam int DIRW   = BKW + NW;
  localparam logic [7:0] MAX_UNITS = 8'(MAX_DATA_BLOCKS * BLOCK_UNITS);

  // Memories
  logic [WORD_BITS-1:0] bm_mem [ROWS];
  logic [DIRW-1:0]      dir_mem [NUM_FILES];
  logic [BKW-1:0]       data_mem [DD];

  logic [WORD_BITS-1:0] bm_rdata_r;
  logic [DIRW-1:0]      dir_rdata_r;
  logic [BKW-1:0]       data_rdata_r;

  logic                 bm_we, bm_re, dir_we, dir_re, data_we, data_re;
  logic [RW-1:0]        bm_waddr, bm_raddr;
  logic [WORD_BITS-1:0] bm_wdata;
  logic [DIRW-1:0]      dir_wdata;
  logic [AW-1:0]        data_addr;
  logic [BKW-1:0]       data_wdata;

  // Registers
  logic [NUM_FILES-1:0] used_r, used_nxt;
  logic [NFW-1:0]       nfree_r, nfree_nxt;
  logic [RW-1:0]        row_r, row_nxt;
  logic [WORD_BITS-1:0] word_r, word_nxt;
  logic                 op_r, op_nxt;
  logic [5:0]           slot_in_r, slot_in_nxt;
  logic [SW-1:0]        fslot_r, fslot_nxt;
  logic                 too_large_r, too_large_nxt;
  logic                 slot_found_r, slot_found_nxt;
  logic [NW-1:0]        cnt_r, cnt_nxt;
  logic [KW-1:0]        k_r, k_nxt;
  logic [GW-1:0]        gcnt_r, gcnt_nxt;
  logic [BKW-1:0]       blk_r, blk_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [OUT_SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [OUT_BLK_W-1:0]  out_blk_r, out_blk_nxt;
  logic                  out_idx_r, out_idx_nxt;
  logic                  out_last_r, out_last_nxt;

  // Combinational helpers
  logic [WORD_BITS-1:0] init_word;
  logic [WORD_LSB-1:0]  zpos;
  logic                 has_zero;
  logic [PADW-1:0]      used_pad;
  logic [GROUP_BITS-1:0] grp;
  logic [2:0]           gpos;
  logic [NW-1:0]        need_c;
  logic [BKW-1:0]       take_blk;
  logic                 last_c;
  logic [STATUS_W-1:0]  err_code;

  // Reset row pattern: block 0 and blocks past the disk read as taken
  always_comb begin
    int bv;
    for (int k = 0; k < WORD_BITS; k++) begin
      bv = int'({row_r, WORD_LSB'(k)});
      init_word[k] = (bv == 0) || (bv >= NUM_BLOCKS);
    end
  end

  // Lowest free block in the held row
  always_comb begin
    zpos = '0;
    for (int k = WORD_BITS - 1; k >= 0; k--) begin
      if (!word_r[k]) zpos = WORD_LSB'(k);
    end
    has_zero = ~&word_r;
  end

  // Directory occupancy, padded to whole groups; slot 0 always taken
  always_comb begin
    used_pad = '1;
    for (int i = 1; i < NUM_FILES; i++) used_pad[i] = used_r[i];
    grp = used_pad[int'(gcnt_r) * GROUP_BITS +: GROUP_BITS];
    gpos = '0;
    for (int i = GROUP_BITS - 1; i >= 0; i--) begin
      if (!grp[i]) gpos = 3'(i);
    end
  end

  // Round the size up to whole blocks by threshold compares
  always_comb begin
    need_c = '0;
    for (int j = 0; j < MAX_DATA_BLOCKS; j++) begin
      if ({3'b000, in_size_units} > 8'(j * BLOCK_UNITS)) need_c = need_c + NW'(1);
    end
  end

  assign take_blk = {row_r, zpos};
  assign last_c   = (k_r == KW'(cnt_r));

  always_comb begin
    if (op_r == OP_DELETE) err_code = ST_SLOT_EMPTY;
    else if (too_large_r)  err_code = ST_TOO_LARGE;
    else if (!slot_found_r) err_code = ST_DIR_FULL;
    else                   err_code = ST_DISK_FULL;
  end

  // Status to the sequencer
  always_comb begin
    sts.clr_done      = (row_r == RW'(ROWS - 1));
    sts.too_large     = too_large_r;
    sts.scan_found    = ~&grp;
    sts.scan_last     = (gcnt_r == GW'(GROUPS - 1));
    sts.disk_full     = (int'(nfree_r) < int'(cnt_r) + 1);
    sts.word_has_zero = has_zero;
    sts.last          = last_c;
    sts.out_free      = !out_valid_r || !out_stall;
    sts.slot_bad      = (slot_in_r == 6'd0) || ({3'b000, slot_in_r} >= 9'(NUM_FILES)) ||
                        !used_r[fslot_r];
  end

  // Next-state logic for all datapath registers and memory controls
  always_comb begin
    used_nxt = used_r;  nfree_nxt = nfree_r;  row_nxt = row_r;  word_nxt = word_r;
    op_nxt = op_r;  slot_in_nxt = slot_in_r;  fslot_nxt = fslot_r;
    too_large_nxt = too_large_r;  slot_found_nxt = slot_found_r;
    cnt_nxt = cnt_r;  k_nxt = k_r;  gcnt_nxt = gcnt_r;  blk_nxt = blk_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_status_nxt = out_status_r;  out_slot_nxt = out_slot_r;  out_blk_nxt = out_blk_r;
    out_idx_nxt = out_idx_r;  out_last_nxt = out_last_r;
    bm_we = 1'b0;  bm_re = 1'b0;  bm_waddr = row_r;  bm_raddr = row_r;  bm_wdata = word_r;
    dir_we = 1'b0;  dir_re = 1'b0;  dir_wdata = {take_blk, cnt_r};
    data_we = 1'b0;  data_re = 1'b0;  data_wdata = take_blk;
    data_addr = AW'(int'(fslot_r) * MAX_DATA_BLOCKS + int'(k_r) - 1);

    // Clear the bitmap one row at a time after reset
    if (cmd.clr_step) begin
      bm_we    = 1'b1;
      bm_wdata = init_word;
      row_nxt  = row_r + RW'(1);
    end
    // Latch the request
    if (cmd.accept) begin
      op_nxt         = in_opcode;
      slot_in_nxt    = in_slot;
      fslot_nxt      = SW'(in_slot);
      too_large_nxt  = ({3'b000, in_size_units} > MAX_UNITS);
      cnt_nxt        = need_c;
      slot_found_nxt = 1'b0;
      gcnt_nxt       = '0;
      row_nxt        = '0;
      k_nxt          = '0;
    end
    // Walk the directory a group at a time
    if (cmd.scan_step) begin
      if (~&grp) begin
        fslot_nxt      = SW'({gcnt_r, gpos});
        slot_found_nxt = 1'b1;
      end else begin
        gcnt_nxt = gcnt_r + GW'(1);
      end
    end
    if (cmd.row_rd) bm_re = 1'b1;
    if (cmd.load_word) word_nxt = bm_rdata_r;
    // Take the lowest free block of the held row
    if (cmd.take) begin
      word_nxt = word_r | (WORD_BITS'(1) << zpos);
      if (k_r == '0) begin
        dir_we = 1'b1;
        used_nxt[fslot_r] = 1'b1;
      end else begin
        data_we = 1'b1;
      end
      if (last_c) begin
        bm_we    = 1'b1;
        bm_wdata = word_nxt;
      end
      k_nxt          = k_r + KW'(1);
      nfree_nxt      = nfree_r - NFW'(1);
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_OK;
      out_slot_nxt   = OUT_SLOT_W'(fslot_r);
      out_blk_nxt    = OUT_BLK_W'(take_blk);
      out_idx_nxt    = (k_r == '0);
      out_last_nxt   = last_c;
    end
    // Write back a full row and advance
    if (cmd.row_next) begin
      bm_we   = 1'b1;
      row_nxt = row_r + RW'(1);
    end
    if (cmd.emit_err) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = err_code;
      out_slot_nxt   = (op_r == OP_DELETE) ? slot_in_r : '0;
      out_blk_nxt    = '0;
      out_idx_nxt    = 1'b0;
      out_last_nxt   = 1'b1;
    end
    if (cmd.dir_rd) dir_re = 1'b1;
    if (cmd.dir_ld) begin
      blk_nxt = dir_rdata_r[DIRW-1:NW];
      cnt_nxt = dir_rdata_r[NW-1:0];
    end
    // Release one block: read its row, then clear its bit
    if (cmd.free_rd) begin
      bm_re    = 1'b1;
      bm_raddr = blk_r[BKW-1:WORD_LSB];
    end
    if (cmd.free_wr) begin
      bm_we    = 1'b1;
      bm_waddr = blk_r[BKW-1:WORD_LSB];
      bm_wdata = bm_rdata_r & ~(WORD_BITS'(1) << blk_r[WORD_LSB-1:0]);
      if (last_c) used_nxt[fslot_r] = 1'b0;
      k_nxt          = k_r + KW'(1);
      nfree_nxt      = nfree_r + NFW'(1);
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_OK;
      out_slot_nxt   = OUT_SLOT_W'(fslot_r);
      out_blk_nxt    = OUT_BLK_W'(blk_r);
      out_idx_nxt    = (k_r == '0);
      out_last_nxt   = last_c;
    end
    if (cmd.data_rd) data_re = 1'b1;
    if (cmd.data_ld) blk_nxt = data_rdata_r;
  end

  // Memory ports
  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
    if (bm_re) bm_rdata_r <= bm_mem[bm_raddr];
  end

  always_ff @(posedge clk) begin
    if (dir_we) dir_mem[fslot_r] <= dir_wdata;
    if (dir_re) dir_rdata_r <= dir_mem[fslot_r];
  end

  always_ff @(posedge clk) begin
    if (data_we) data_mem[data_addr] <= data_wdata;
    if (data_re) data_rdata_r <= data_mem[data_addr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      nfree_r     <= NFW'(NUM_BLOCKS - 1);
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      nfree_r     <= nfree_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    word_r       <= word_nxt;
    op_r         <= op_nxt;
    slot_in_r    <= slot_in_nxt;
    fslot_r      <= fslot_nxt;
    too_large_r  <= too_large_nxt;
    slot_found_r <= slot_found_nxt;
    cnt_r        <= cnt_nxt;
    k_r          <= k_nxt;
    gcnt_r       <= gcnt_nxt;
    blk_r        <= blk_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_blk_r    <= out_blk_nxt;
    out_idx_r    <= out_idx_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_file_slot    = out_slot_r;
  assign out_block_number = out_blk_r;
  assign out_is_index     = out_idx_r;
  assign out_last         = out_last_r;

endmodule

[rtl/core/iba_ctrl.sv]
// Sequencer of the block allocator: steps the datapath through clear, create and delete.
module iba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_opcode,
  output logic               in_stall,
  input  iba_pkg::iba_sts_t  sts,
  output iba_pkg::iba_cmd_t  cmd
);
  import iba_pkg::*;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_ERR   = 4'd3;
  localparam logic [3:0] S_ARD   = 4'd4;
  localparam logic [3:0] S_ALD   = 4'd5;
  localparam logic [3:0] S_AFIND = 4'd6;
  localparam logic [3:0] S_DCHK  = 4'd7;
  localparam logic [3:0] S_DDL   = 4'd8;
  localparam logic [3:0] S_FRD   = 4'd9;
  localparam logic [3:0] S_FWR   = 4'd10;
  localparam logic [3:0] S_DRD   = 4'd11;
  localparam logic [3:0] S_DDLD  = 4'd12;

  logic [3:0] state_r, state_nxt;

  // Advance the sequence and issue at most one step per cycle; output steps wait while the output is stalled
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = (in_opcode == OP_DELETE) ? S_DCHK : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.too_large) begin
          state_nxt = S_ERR;
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.scan_found) state_nxt = sts.disk_full ? S_ERR : S_ARD;
          else if (sts.scan_last) state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        if (sts.out_free) begin
          cmd.emit_err = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_ARD: begin
        cmd.row_rd = 1'b1;
        state_nxt  = S_ALD;
      end
      S_ALD: begin
        cmd.load_word = 1'b1;
        state_nxt     = S_AFIND;
      end
      S_AFIND: begin
        if (!sts.word_has_zero) begin
          cmd.row_next = 1'b1;
          state_nxt    = S_ARD;
        end else if (sts.out_free) begin
          cmd.take = 1'b1;
          if (sts.last) state_nxt = S_IDLE;
        end
      end
      S_DCHK: begin
        cmd.dir_rd = 1'b1;
        state_nxt  = sts.slot_bad ? S_ERR : S_DDL;
      end
      S_DDL: begin
        cmd.dir_ld = 1'b1;
        state_nxt  = S_FRD;
      end
      S_FRD: begin
        cmd.free_rd = 1'b1;
        state_nxt   = S_FWR;
      end
      S_FWR: begin
        if (sts.out_free) begin
          cmd.free_wr = 1'b1;
          state_nxt   = sts.last ? S_IDLE : S_DRD;
        end
      end
      S_DRD: begin
        cmd.data_rd = 1'b1;
        state_nxt   = S_DDLD;
      end
      S_DDLD: begin
        cmd.data_ld = 1'b1;
        state_nxt   = S_FRD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else        state_r <= state_nxt;
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

[tb/tb.sv]
// Self-checking testbench for the indexed block allocator: create/delete traffic vs a predictor.
module tb;
  import iba_pkg::*;

  localparam int NBLK = 512;
  localparam int NSLOT = 64;
  localparam int MAXD = 5;
  localparam int UNITS = 4;

  typedef struct packed {
    logic       opcode;
    logic [4:0] size_units;
    logic [5:0] slot;
  } request_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] file_slot;
    logic [8:0] block_number;
    logic       is_index;
    logic       last;
  } alloc_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_opcode;
  logic [4:0]  in_size_units;
  logic [5:0]  in_slot;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [5:0]  out_file_slot;
  logic [8:0]  out_block_number;
  logic        out_is_index;
  logic        out_last;

  // predictor state
  bit         used_map [NBLK];
  logic [8:0] slot_index [NSLOT];
  int         slot_count [NSLOT];
  logic [8:0] slot_data [NSLOT][MAXD];

  request_t      pending_reqs[$];
  alloc_result_t expected_allocs[$];
  int            n_errors = 0;
  bit            hold_sender = 0;
  int            gap_left = 0;
  int            burst_left = 0;

  indexed_block_allocator dut (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic int lowest_free();
    for (int b = 1; b < NBLK; b++) if (!used_map[b]) return b;
    return 0;
  endfunction

  function automatic void push_result(logic [2:0] st, int fs, int blk, bit idx, bit lst);
    alloc_result_t r;
    r.status = st; r.file_slot = fs[5:0]; r.block_number = blk[8:0];
    r.is_index = idx; r.last = lst;
    expected_allocs.push_back(r);
  endfunction

  // Work out the results of one accepted request and update the predicted state
  function automatic void predict_alloc(request_t q);
    int need, fs, nfree, blk;
    if (q.opcode == OP_CREATE) begin
      need = (int'(q.size_units) + UNITS - 1) / UNITS;
      fs = 0;
      nfree = 0;
      if (need > MAXD) begin
        push_result(ST_TOO_LARGE, 0, 0, 0, 1);
        return;
      end
      for (int s = 1; s < NSLOT; s++) if (slot_index[s] == 0 && fs == 0) fs = s;
      if (fs == 0) begin
        push_result(ST_DIR_FULL, 0, 0, 0, 1);
        return;
      end
      for (int b = 1; b < NBLK; b++) if (!used_map[b]) nfree++;
      if (nfree < need + 1) begin
        push_result(ST_DISK_FULL, 0, 0, 0, 1);
        return;
      end
      blk = lowest_free();
      used_map[blk] = 1;
      slot_index[fs] = blk[8:0];
      slot_count[fs] = need;
      push_result(ST_OK, fs, blk, 1, need == 0);
      for (int j = 0; j < need; j++) begin
        blk = lowest_free();
        used_map[blk] = 1;
        slot_data[fs][j] = blk[8:0];
        push_result(ST_OK, fs, blk, 0, j + 1 == need);
      end
    end else begin
      fs = int'(q.slot);
      if (fs == 0 || slot_index[fs] == 0) begin
        push_result(ST_SLOT_EMPTY, fs, 0, 0, 1);
        return;
      end
      used_map[slot_index[fs]] = 0;
      push_result(ST_OK, fs, slot_index[fs], 1, slot_count[fs] == 0);
      for (int j = 0; j < slot_count[fs]; j++) begin
        used_map[slot_data[fs][j]] = 0;
        push_result(ST_OK, fs, slot_data[fs][j], 0, j + 1 == slot_count[fs]);
      end
      slot_index[fs] = 0;
      slot_count[fs] = 0;
    end
  endfunction

  function automatic request_t mk_req(bit op, int sz, int sl);
    request_t q;
    q.opcode = op; q.size_units = sz[4:0]; q.slot = sl[5:0];
    return q;
  endfunction

  // Driver: advance through pending requests in bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_opcode <= 1'b0;
      in_size_units <= '0;
      in_slot <= '0;
      for (int b = 0; b < NBLK; b++) used_map[b] = 0;
      for (int s = 0; s < NSLOT; s++) begin
        slot_index[s] = '0;
        slot_count[s] = 0;
      end
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) predict_alloc({in_opcode, in_size_units, in_slot});
      if (pending_reqs.size() > 0 && !hold_sender && gap_left == 0) begin
        request_t q;
        q = pending_reqs.pop_front();
        in_valid <= 1'b1;
        in_opcode <= q.opcode;
        in_size_units <= q.size_units;
        in_slot <= q.slot;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 9);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // Receiver stall pattern: alternate calm and busy stretches
  int stall_phase = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      stall_phase = (stall_phase + 1) % 400;
      out_stall <= (stall_phase < 120) ? 1'b0 : ($urandom_range(0, 99) < 45);
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      alloc_result_t got, exp_r;
      got = {out_status, out_file_slot, out_block_number, out_is_index, out_last};
      if (expected_allocs.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        n_errors++;
      end else begin
        exp_r = expected_allocs.pop_front();
        if (got.status !== exp_r.status) begin
          $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
          n_errors++;
        end
        if (got.file_slot !== exp_r.file_slot) begin
          $display("%0t: file_slot exp %0d got %0d", $time, exp_r.file_slot, got.file_slot);
          n_errors++;
        end
        if (got.block_number !== exp_r.block_number) begin
          $display("%0t: block_number exp %0d got %0d", $time, exp_r.block_number,
                   got.block_number);
          n_errors++;
        end
        if (got.is_index !== exp_r.is_index) begin
          $display("%0t: is_index exp %0d got %0d", $time, exp_r.is_index, got.is_index);
          n_errors++;
        end
        if (got.last !== exp_r.last) begin
          $display("%0t: last exp %0d got %0d", $time, exp_r.last, got.last);
          n_errors++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int live;
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: size extremes, too large, empty/zero/unused slot deletes
    pending_reqs.push_back(mk_req(OP_DELETE, 0, 0));
    pending_reqs.push_back(mk_req(OP_DELETE, 31, 63));
    pending_reqs.push_back(mk_req(OP_CREATE, 0, 0));
    pending_reqs.push_back(mk_req(OP_CREATE, 1, 63));
    pending_reqs.push_back(mk_req(OP_CREATE, 20, 0));
    pending_reqs.push_back(mk_req(OP_CREATE, 21, 0));
    pending_reqs.push_back(mk_req(OP_CREATE, 31, 42));
    pending_reqs.push_back(mk_req(OP_CREATE, 4, 0));
    pending_reqs.push_back(mk_req(OP_CREATE, 5, 0));
    pending_reqs.push_back(mk_req(OP_DELETE, 3, 2));
    pending_reqs.push_back(mk_req(OP_DELETE, 0, 2));
    pending_reqs.push_back(mk_req(OP_CREATE, 16, 0));
    pending_reqs.push_back(mk_req(OP_DELETE, 0, 1));
    pending_reqs.push_back(mk_req(OP_DELETE, 0, 3));
    // fill the directory, then hit directory full
    for (int i = 0; i < 66; i++) pending_reqs.push_back(mk_req(OP_CREATE, 0, $urandom));

    // hold the sender until every expected result has come
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    hold_sender = 1;
    while (in_valid || expected_allocs.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
    hold_sender = 0;

    // free everything, then create 40 big files and free the slots that are not multiples of 3
    for (int s = 1; s < NSLOT; s++) pending_reqs.push_back(mk_req(OP_DELETE, $urandom, s));
    for (int i = 0; i < 40; i++) pending_reqs.push_back(mk_req(OP_CREATE, 20, $urandom));
    for (int s = 1; s < NSLOT; s++)
      if (s % 3 != 0) pending_reqs.push_back(mk_req(OP_DELETE, $urandom, s));

    // random mix: mostly deletes of slots 1 to 40 and legal creates
    for (int i = 0; i < 40; i++) begin
      case ($urandom_range(0, 9))
        0: pending_reqs.push_back(mk_req($urandom_range(0, 1), $urandom, $urandom));
        1, 2, 3, 4: pending_reqs.push_back(mk_req(OP_DELETE, $urandom, $urandom_range(1, 40)));
        default: pending_reqs.push_back(mk_req(OP_CREATE, $urandom_range(0, 20), $urandom));
      endcase
    end
    for (int s = 0; s < NSLOT; s++) pending_reqs.push_back(mk_req(OP_DELETE, $urandom, s));

    wait (pending_reqs.size() == 0);
    @(posedge clk);
    while (in_valid || expected_allocs.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    live = n_errors + expected_allocs.size();
    if (live == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end
endmodule
